### rtl/jddm_pkg.sv
package jddm_pkg;

   // Field widths fixed by the register map and the beat formats.
   localparam int STICK_W = 8;
   localparam int GAIN_W  = 12;
   localparam int ALPHA_W = 17;
   localparam int LIMIT_W = 19;
   localparam int PULSE_W = 19;
   localparam int VALUE_W = 21;
   localparam int CSR_DATA_W  = 19;
   localparam int CSR_INDEX_W = 3;

   // Register reset values.
   localparam logic [ALPHA_W-1:0] SMOOTHING_RESET     = 17'd13107;
   localparam logic [LIMIT_W-1:0] MAX_STEP_RESET      = 19'd3280;
   localparam logic [GAIN_W-1:0]  THROTTLE_GAIN_RESET = 12'd2400;
   localparam logic [GAIN_W-1:0]  STEER_GAIN_RESET    = 12'd1600;
   localparam logic [LIMIT_W-1:0] THROTTLE_CAP_RESET  = 19'd320000;
   localparam logic [LIMIT_W-1:0] STEER_CAP_RESET     = 19'd256000;
   localparam logic [LIMIT_W-1:0] LEFT_LIMIT_RESET    = 19'd320000;
   localparam logic [LIMIT_W-1:0] RIGHT_LIMIT_RESET   = 19'd256000;

   // Stick centre readings.
   localparam logic signed [STICK_W:0] Y_CENTRE = 9'sd128;
   localparam logic signed [STICK_W:0] X_CENTRE = 9'sd127;

   // Register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SMOOTHING     = 3'd0,
      CSR_MAX_STEP      = 3'd1,
      CSR_THROTTLE_GAIN = 3'd2,
      CSR_STEER_GAIN    = 3'd3,
      CSR_THROTTLE_CAP  = 3'd4,
      CSR_STEER_CAP     = 3'd5,
      CSR_LEFT_LIMIT    = 3'd6,
      CSR_RIGHT_LIMIT   = 3'd7
   } csr_index_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RAW_T,
      ST_FILT_T,
      ST_POST_T,
      ST_RAW_S,
      ST_FILT_S,
      ST_POST_S,
      ST_MIX
   } state_type;

   // Operations of the shared multiplier.
   typedef enum logic [1:0] {
      OP_HOLD,
      OP_RAW,
      OP_FILT
   } op_type;

   typedef struct packed {
      op_type op;
      logic   steer;
   } ctrl_type;

endpackage

### rtl/jddm_req_if.sv
interface jddm_req_if;
   logic                         valid;
   logic                         ready;
   logic [jddm_pkg::STICK_W-1:0] stick_y;
   logic [jddm_pkg::STICK_W-1:0] stick_x;

   modport source (output valid, output stick_y, output stick_x, input ready);
   modport sink (input valid, input stick_y, input stick_x, output ready);
endinterface

### rtl/jddm_rsp_if.sv
interface jddm_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         left_in1;
   logic                         left_in2;
   logic [jddm_pkg::PULSE_W-1:0] left_pulse;
   logic                         right_in1;
   logic                         right_in2;
   logic [jddm_pkg::PULSE_W-1:0] right_pulse;

   modport source (output valid, output left_in1, output left_in2, output left_pulse,
                   output right_in1, output right_in2, output right_pulse, input ready);
   modport sink (input valid, input left_in1, input left_in2, input left_pulse,
                 input right_in1, input right_in2, input right_pulse, output ready);
endinterface

### rtl/jddm_filter_unit.sv
module jddm_filter_unit #(
   parameter int ALPHA_FRAC_BITS = 16
) (
   input  logic                                clock,
   input  jddm_pkg::ctrl_type                  ctrl,
   input  logic [jddm_pkg::STICK_W-1:0]        stick_y,
   input  logic [jddm_pkg::STICK_W-1:0]        stick_x,
   input  logic [jddm_pkg::GAIN_W-1:0]         throttle_gain,
   input  logic [jddm_pkg::GAIN_W-1:0]         steer_gain,
   input  logic [jddm_pkg::ALPHA_W-1:0]        smoothing_factor,
   input  logic [jddm_pkg::LIMIT_W-1:0]        max_step,
   input  logic [jddm_pkg::LIMIT_W-1:0]        throttle_cap,
   input  logic [jddm_pkg::LIMIT_W-1:0]        steer_cap,
   input  logic signed [jddm_pkg::VALUE_W-1:0] prev_throttle,
   input  logic signed [jddm_pkg::VALUE_W-1:0] prev_steer,
   output logic signed [jddm_pkg::VALUE_W-1:0] result
);

   localparam int VW = jddm_pkg::VALUE_W;
   localparam int DW = VW + 1;
   localparam int AW = ALPHA_FRAC_BITS + 1;
   localparam int CW = (AW > jddm_pkg::ALPHA_W) ? AW : jddm_pkg::ALPHA_W;
   localparam int MB = ((AW > jddm_pkg::GAIN_W) ? AW : jddm_pkg::GAIN_W) + 1;
   localparam int PW = DW + MB;
   localparam int SW = PW + 1;

   logic [CW-1:0]                     sf_ext;
   logic [CW-1:0]                     one_ext;
   logic [CW-1:0]                     a_sat;
   logic signed [VW-1:0]              prev;
   logic [jddm_pkg::LIMIT_W-1:0]      cap;
   logic signed [jddm_pkg::STICK_W:0] offs;
   logic [jddm_pkg::GAIN_W-1:0]       gain;
   logic signed [DW-1:0]              op_a;
   logic signed [MB-1:0]              op_b;
   logic signed [PW-1:0]              prod;
   logic signed [PW-1:0]              prod_in;
   logic signed [PW-1:0]              prod_ff;
   logic signed [SW-1:0]              sum;
   logic signed [SW-1:0]              shr;
   logic                              round_up;
   logic signed [DW-1:0]              filt;
   logic signed [DW-1:0]              delta;
   logic signed [DW-1:0]              step;
   logic signed [DW-1:0]              delta_cl;
   logic signed [DW-1:0]              slewed;
   logic signed [DW-1:0]              cap_s;

   // Weight of the new sample, saturated to one.
   assign sf_ext  = CW'(smoothing_factor);
   assign one_ext = CW'(1) << ALPHA_FRAC_BITS;
   assign a_sat   = (sf_ext > one_ext) ? one_ext : sf_ext;

   // Channel selection: throttle or steer.
   always_comb begin
      prev = ctrl.steer ? prev_steer : prev_throttle;
      cap  = ctrl.steer ? steer_cap : throttle_cap;
      gain = ctrl.steer ? steer_gain : throttle_gain;
      if (ctrl.steer) begin
         offs = jddm_pkg::X_CENTRE - $signed({1'b0, stick_x});
      end else begin
         offs = jddm_pkg::Y_CENTRE - $signed({1'b0, stick_y});
      end
   end

   // Shared multiplier: stick offset times gain, or weight times (raw - prev).
   always_comb begin
      case (ctrl.op)
         jddm_pkg::OP_RAW: begin
            op_a = DW'(offs);
            op_b = $signed(MB'(gain));
         end
         jddm_pkg::OP_FILT: begin
            op_a = DW'($signed(prod_ff[VW-1:0])) - DW'(prev);
            op_b = $signed(MB'(a_sat[AW-1:0]));
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
      prod    = op_a * op_b;
      prod_in = (ctrl.op == jddm_pkg::OP_HOLD) ? prod_ff : prod;
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // Blend, truncated toward zero, then slew limit and upper cap.
   always_comb begin
      sum      = (SW'(prev) <<< ALPHA_FRAC_BITS) + SW'(prod_ff);
      shr      = sum >>> ALPHA_FRAC_BITS;
      round_up = sum[SW-1] && (|sum[ALPHA_FRAC_BITS-1:0]);
      filt     = DW'(shr) + DW'(round_up);
      delta    = filt - DW'(prev);
      step     = $signed(DW'(max_step));
      if (delta > step) begin
         delta_cl = step;
      end else if (delta < -step) begin
         delta_cl = -step;
      end else begin
         delta_cl = delta;
      end
      slewed = DW'(prev) + delta_cl;
      cap_s  = $signed(DW'(cap));
      if (slewed > cap_s) begin
         result = cap_s[VW-1:0];
      end else begin
         result = slewed[VW-1:0];
      end
   end

endmodule

### rtl/joystick_differential_drive_mixer_core.sv
// Arcade-drive mixer for a two-motor differential drive.
// The req channel carries one beat per control tick with two stick readings.
// The rsp channel returns one beat per request: direction pin levels and the
// PWM pulse width of the left and right motors.
// The csr port writes one of eight registers at each clock edge with csr_we
// high; the user must make writes only while no request is in flight, which
// the block itself does not enforce. A request passes from acceptance to the
// response register through one shared multiplier used four times (two gain
// products, two filter products), with a filter/slew/cap step after each
// filter product and a final mixing step. The next request is taken in the
// cycle after the response is loaded, so one request is worked on at a time.
// The response register holds its beat while rsp is stalled; a new request
// may be accepted meanwhile and then waits in its mixing step until the
// held beat is taken.
// Reset restores the register defaults and clears the stored throttle and
// steer values and all handshake state.
module joystick_differential_drive_mixer_core #(
   parameter int ALPHA_FRAC_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   jddm_req_if.sink                              req_bus,
   jddm_rsp_if.source                            rsp_bus,
   input  logic                                  csr_we,
   input  logic [jddm_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [jddm_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int VW = jddm_pkg::VALUE_W;
   localparam int DW = VW + 1;

   jddm_pkg::state_type state_ff, state_in;
   jddm_pkg::ctrl_type  ctrl;

   logic [jddm_pkg::ALPHA_W-1:0] smoothing_ff, smoothing_in;
   logic [jddm_pkg::LIMIT_W-1:0] max_step_ff, max_step_in;
   logic [jddm_pkg::GAIN_W-1:0]  throttle_gain_ff, throttle_gain_in;
   logic [jddm_pkg::GAIN_W-1:0]  steer_gain_ff, steer_gain_in;
   logic [jddm_pkg::LIMIT_W-1:0] throttle_cap_ff, throttle_cap_in;
   logic [jddm_pkg::LIMIT_W-1:0] steer_cap_ff, steer_cap_in;
   logic [jddm_pkg::LIMIT_W-1:0] left_limit_ff, left_limit_in;
   logic [jddm_pkg::LIMIT_W-1:0] right_limit_ff, right_limit_in;

   logic [jddm_pkg::STICK_W-1:0] stick_y_ff, stick_y_in;
   logic [jddm_pkg::STICK_W-1:0] stick_x_ff, stick_x_in;
   logic signed [VW-1:0]         last_t_ff, last_t_in;
   logic signed [VW-1:0]         last_s_ff, last_s_in;
   logic signed [VW-1:0]         unit_result;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         left_pos_ff, left_pos_in;
   logic                         right_pos_ff, right_pos_in;
   logic [jddm_pkg::PULSE_W-1:0] left_pulse_ff, left_pulse_in;
   logic [jddm_pkg::PULSE_W-1:0] right_pulse_ff, right_pulse_in;

   logic                         accept;
   logic                         out_free;
   logic                         load_out;
   logic                         store_t;
   logic                         store_s;

   logic signed [DW-1:0]         left_raw, right_raw;
   logic signed [DW-1:0]         left_lim, right_lim;
   logic signed [DW-1:0]         left_v, right_v;
   logic signed [DW-1:0]         left_abs, right_abs;

   // Shared arithmetic unit.
   jddm_filter_unit #(
      .ALPHA_FRAC_BITS (ALPHA_FRAC_BITS)
   ) u_filter (
      .clock            (clock),
      .ctrl             (ctrl),
      .stick_y          (stick_y_ff),
      .stick_x          (stick_x_ff),
      .throttle_gain    (throttle_gain_ff),
      .steer_gain       (steer_gain_ff),
      .smoothing_factor (smoothing_ff),
      .max_step         (max_step_ff),
      .throttle_cap     (throttle_cap_ff),
      .steer_cap        (steer_cap_ff),
      .prev_throttle    (last_t_ff),
      .prev_steer       (last_s_ff),
      .result           (unit_result)
   );

   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign accept   = req_bus.valid && req_bus.ready;

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         jddm_pkg::ST_IDLE:   if (req_bus.valid) state_in = jddm_pkg::ST_RAW_T;
         jddm_pkg::ST_RAW_T:  state_in = jddm_pkg::ST_FILT_T;
         jddm_pkg::ST_FILT_T: state_in = jddm_pkg::ST_POST_T;
         jddm_pkg::ST_POST_T: state_in = jddm_pkg::ST_RAW_S;
         jddm_pkg::ST_RAW_S:  state_in = jddm_pkg::ST_FILT_S;
         jddm_pkg::ST_FILT_S: state_in = jddm_pkg::ST_POST_S;
         jddm_pkg::ST_POST_S: state_in = jddm_pkg::ST_MIX;
         jddm_pkg::ST_MIX:    if (out_free) state_in = jddm_pkg::ST_IDLE;
         default:             state_in = jddm_pkg::ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      ctrl.op       = jddm_pkg::OP_HOLD;
      ctrl.steer    = 1'b0;
      req_bus.ready = 1'b0;
      store_t       = 1'b0;
      store_s       = 1'b0;
      load_out      = 1'b0;
      unique case (state_ff)
         jddm_pkg::ST_IDLE:   req_bus.ready = !reset;
         jddm_pkg::ST_RAW_T:  ctrl.op = jddm_pkg::OP_RAW;
         jddm_pkg::ST_FILT_T: ctrl.op = jddm_pkg::OP_FILT;
         jddm_pkg::ST_POST_T: store_t = 1'b1;
         jddm_pkg::ST_RAW_S: begin
            ctrl.op    = jddm_pkg::OP_RAW;
            ctrl.steer = 1'b1;
         end
         jddm_pkg::ST_FILT_S: begin
            ctrl.op    = jddm_pkg::OP_FILT;
            ctrl.steer = 1'b1;
         end
         jddm_pkg::ST_POST_S: begin
            ctrl.steer = 1'b1;
            store_s    = 1'b1;
         end
         jddm_pkg::ST_MIX:    load_out = out_free;
         default:             ctrl.op = jddm_pkg::OP_HOLD;
      endcase
   end

   // Register writes.
   always_comb begin
      smoothing_in     = smoothing_ff;
      max_step_in      = max_step_ff;
      throttle_gain_in = throttle_gain_ff;
      steer_gain_in    = steer_gain_ff;
      throttle_cap_in  = throttle_cap_ff;
      steer_cap_in     = steer_cap_ff;
      left_limit_in    = left_limit_ff;
      right_limit_in   = right_limit_ff;
      if (csr_we) begin
         unique case (jddm_pkg::csr_index_type'(csr_index))
            jddm_pkg::CSR_SMOOTHING:     smoothing_in     = csr_wdata[jddm_pkg::ALPHA_W-1:0];
            jddm_pkg::CSR_MAX_STEP:      max_step_in      = csr_wdata;
            jddm_pkg::CSR_THROTTLE_GAIN: throttle_gain_in = csr_wdata[jddm_pkg::GAIN_W-1:0];
            jddm_pkg::CSR_STEER_GAIN:    steer_gain_in    = csr_wdata[jddm_pkg::GAIN_W-1:0];
            jddm_pkg::CSR_THROTTLE_CAP:  throttle_cap_in  = csr_wdata;
            jddm_pkg::CSR_STEER_CAP:     steer_cap_in     = csr_wdata;
            jddm_pkg::CSR_LEFT_LIMIT:    left_limit_in    = csr_wdata;
            jddm_pkg::CSR_RIGHT_LIMIT:   right_limit_in   = csr_wdata;
            default:                     right_limit_in   = right_limit_ff;
         endcase
      end
   end

   // Mixing, symmetric clamps and magnitudes.
   always_comb begin
      left_raw  = DW'(last_t_ff) + DW'(last_s_ff);
      right_raw = DW'(last_t_ff) - DW'(last_s_ff);
      left_lim  = $signed(DW'(left_limit_ff));
      right_lim = $signed(DW'(right_limit_ff));
      if (left_raw > left_lim) begin
         left_v = left_lim;
      end else if (left_raw < -left_lim) begin
         left_v = -left_lim;
      end else begin
         left_v = left_raw;
      end
      if (right_raw > right_lim) begin
         right_v = right_lim;
      end else if (right_raw < -right_lim) begin
         right_v = -right_lim;
      end else begin
         right_v = right_raw;
      end
      left_abs       = left_v[DW-1] ? -left_v : left_v;
      right_abs      = right_v[DW-1] ? -right_v : right_v;
      left_pulse_in  = load_out ? left_abs[jddm_pkg::PULSE_W-1:0] : left_pulse_ff;
      right_pulse_in = load_out ? right_abs[jddm_pkg::PULSE_W-1:0] : right_pulse_ff;
      left_pos_in    = load_out ? (left_v > DW'(0)) : left_pos_ff;
      right_pos_in   = load_out ? (right_v > DW'(0)) : right_pos_ff;
   end

   // Captured stick readings, stored state and response valid.
   always_comb begin
      stick_y_in   = accept ? req_bus.stick_y : stick_y_ff;
      stick_x_in   = accept ? req_bus.stick_x : stick_x_ff;
      last_t_in    = store_t ? unit_result : last_t_ff;
      last_s_in    = store_s ? unit_result : last_s_ff;
      rsp_valid_in = load_out || (rsp_valid_ff && !rsp_bus.ready);
   end

   // Control state and registers with reset values.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= jddm_pkg::ST_IDLE;
         rsp_valid_ff     <= 1'b0;
         last_t_ff        <= '0;
         last_s_ff        <= '0;
         smoothing_ff     <= jddm_pkg::SMOOTHING_RESET;
         max_step_ff      <= jddm_pkg::MAX_STEP_RESET;
         throttle_gain_ff <= jddm_pkg::THROTTLE_GAIN_RESET;
         steer_gain_ff    <= jddm_pkg::STEER_GAIN_RESET;
         throttle_cap_ff  <= jddm_pkg::THROTTLE_CAP_RESET;
         steer_cap_ff     <= jddm_pkg::STEER_CAP_RESET;
         left_limit_ff    <= jddm_pkg::LEFT_LIMIT_RESET;
         right_limit_ff   <= jddm_pkg::RIGHT_LIMIT_RESET;
      end else begin
         state_ff         <= state_in;
         rsp_valid_ff     <= rsp_valid_in;
         last_t_ff        <= last_t_in;
         last_s_ff        <= last_s_in;
         smoothing_ff     <= smoothing_in;
         max_step_ff      <= max_step_in;
         throttle_gain_ff <= throttle_gain_in;
         steer_gain_ff    <= steer_gain_in;
         throttle_cap_ff  <= throttle_cap_in;
         steer_cap_ff     <= steer_cap_in;
         left_limit_ff    <= left_limit_in;
         right_limit_ff   <= right_limit_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      stick_y_ff     <= stick_y_in;
      stick_x_ff     <= stick_x_in;
      left_pos_ff    <= left_pos_in;
      right_pos_ff   <= right_pos_in;
      left_pulse_ff  <= left_pulse_in;
      right_pulse_ff <= right_pulse_in;
   end

   // Response beat.
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.left_in1    = !left_pos_ff;
   assign rsp_bus.left_in2    = left_pos_ff;
   assign rsp_bus.left_pulse  = left_pulse_ff;
   assign rsp_bus.right_in1   = right_pos_ff;
   assign rsp_bus.right_in2   = !right_pos_ff;
   assign rsp_bus.right_pulse = right_pulse_ff;

endmodule

### tb/joystick_differential_drive_mixer_core_test.sv
module joystick_differential_drive_mixer_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC_BITS   = 16;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_TICKS = 160;
   localparam int PHASE_COUNT = 10;
   localparam int VW          = jddm_pkg::VALUE_W;
   localparam int PW          = jddm_pkg::PULSE_W;
   localparam int CW          = jddm_pkg::CSR_DATA_W;

   typedef struct {
      logic [jddm_pkg::STICK_W-1:0] stick_y;
      logic [jddm_pkg::STICK_W-1:0] stick_x;
   } stick_pair_type;

   typedef struct {
      logic          left_in1;
      logic          left_in2;
      logic [PW-1:0] left_pulse;
      logic          right_in1;
      logic          right_in2;
      logic [PW-1:0] right_pulse;
   } motor_drive_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                             csr_we;
   logic [jddm_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [CW-1:0]                    csr_wdata;

   jddm_req_if req_bus ();
   jddm_rsp_if rsp_bus ();

   joystick_differential_drive_mixer_core #(
      .ALPHA_FRAC_BITS(FRAC_BITS)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .rsp_bus  (rsp_bus),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   // Mixer settings as the block should hold them.
   logic [jddm_pkg::ALPHA_W-1:0] smooth_weight;
   logic [jddm_pkg::LIMIT_W-1:0] slew_step;
   logic [jddm_pkg::GAIN_W-1:0]  y_gain;
   logic [jddm_pkg::GAIN_W-1:0]  x_gain;
   logic [jddm_pkg::LIMIT_W-1:0] throttle_ceiling;
   logic [jddm_pkg::LIMIT_W-1:0] steer_ceiling;
   logic [jddm_pkg::LIMIT_W-1:0] left_clamp;
   logic [jddm_pkg::LIMIT_W-1:0] right_clamp;

   // Throttle and steer carried over from the previous tick.
   logic signed [VW-1:0] throttle_state;
   logic signed [VW-1:0] steer_state;

   // Register values to be loaded in the next write burst, in index order.
   logic [CW-1:0] setup [8];

   stick_pair_type  stick_queue [$];
   motor_drive_type drive_queue [$];
   int              error_count = 0;
   int              cycle_count = 0;
   bit              steady_flow = 1'b0;
   motor_drive_type want;

   // Low-pass blend towards the new sample, then slew limit, then the upper cap.
   function automatic longint filter_towards(longint target, longint prev, longint cap);
      longint unity, w, f, d, step;
      unity = longint'(1) << FRAC_BITS;
      w = longint'(smooth_weight);
      step = longint'(slew_step);
      if (w > unity) begin
         w = unity;
      end
      f = (w * target + (unity - w) * prev) / unity;
      d = f - prev;
      if (d > step) begin
         d = step;
      end else if (d < -step) begin
         d = -step;
      end
      f = prev + d;
      if (f > cap) begin
         f = cap;
      end
      return f;
   endfunction

   function automatic longint clamp_both_ways(longint v, longint lim);
      if (v > lim) begin
         return lim;
      end
      if (v < -lim) begin
         return -lim;
      end
      return v;
   endfunction

   // One control tick: advances the stored throttle and steer, returns the motor drive.
   function automatic motor_drive_type mix_tick(stick_pair_type s);
      motor_drive_type d;
      longint raw_t, raw_s, t, st, lv, rv, yc, xc;
      yc = longint'(jddm_pkg::Y_CENTRE);
      xc = longint'(jddm_pkg::X_CENTRE);
      raw_t = (yc - longint'(s.stick_y)) * longint'(y_gain);
      raw_s = (xc - longint'(s.stick_x)) * longint'(x_gain);
      t  = filter_towards(raw_t, longint'(throttle_state), longint'(throttle_ceiling));
      st = filter_towards(raw_s, longint'(steer_state), longint'(steer_ceiling));
      lv = clamp_both_ways(t + st, longint'(left_clamp));
      rv = clamp_both_ways(t - st, longint'(right_clamp));
      throttle_state = VW'(t);
      steer_state = VW'(st);
      d.left_in1    = (lv > 0) ? 1'b0 : 1'b1;
      d.left_in2    = (lv > 0) ? 1'b1 : 1'b0;
      d.left_pulse  = PW'((lv < 0) ? -lv : lv);
      d.right_in1   = (rv > 0) ? 1'b1 : 1'b0;
      d.right_in2   = (rv > 0) ? 1'b0 : 1'b1;
      d.right_pulse = PW'((rv < 0) ? -rv : rv);
      return d;
   endfunction

   function automatic void check_field(string name, longint unsigned exp_v, longint unsigned got_v);
      if (exp_v != got_v) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
         error_count++;
      end
   endfunction

   // Sender: presents queued stick beats and predicts each one as it is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid   <= 1'b0;
         req_bus.stick_y <= '0;
         req_bus.stick_x <= '0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            drive_queue.push_back(mix_tick('{req_bus.stick_y, req_bus.stick_x}));
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (stick_queue.size() > 0 && (steady_flow || $urandom_range(0, 99) >= 10)) begin
               stick_pair_type p;
               p = stick_queue.pop_front();
               req_bus.valid   <= 1'b1;
               req_bus.stick_y <= p.stick_y;
               req_bus.stick_x <= p.stick_x;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: checks each drive beat against the oldest prediction.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (drive_queue.size() == 0) begin
               $display("%0t: drive beat with none expected, left %0d right %0d", $time,
                        rsp_bus.left_pulse, rsp_bus.right_pulse);
               error_count++;
            end else begin
               want = drive_queue.pop_front();
               check_field("left_in1", 64'(want.left_in1), 64'(rsp_bus.left_in1));
               check_field("left_in2", 64'(want.left_in2), 64'(rsp_bus.left_in2));
               check_field("left_pulse", 64'(want.left_pulse), 64'(rsp_bus.left_pulse));
               check_field("right_in1", 64'(want.right_in1), 64'(rsp_bus.right_in1));
               check_field("right_in2", 64'(want.right_in2), 64'(rsp_bus.right_in2));
               check_field("right_pulse", 64'(want.right_pulse), 64'(rsp_bus.right_pulse));
            end
         end
         rsp_bus.ready <= steady_flow || ($urandom_range(0, 99) >= 10);
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Waits until every queued beat has been taken and every drive beat checked.
   task automatic drain();
      do begin
         @(negedge clock);
      end while (stick_queue.size() != 0 || req_bus.valid || drive_queue.size() != 0);
   endtask

   // Writes all eight registers from setup[], one per clock edge.
   task automatic load_setup();
      jddm_pkg::csr_index_type idx;
      repeat (8) @(posedge clock);
      for (int i = 0; i < 8; i++) begin
         idx = jddm_pkg::csr_index_type'(i);
         @(posedge clock);
         csr_we    <= 1'b1;
         csr_index <= idx;
         csr_wdata <= setup[i];
         case (idx)
            jddm_pkg::CSR_SMOOTHING:     smooth_weight    = setup[i][jddm_pkg::ALPHA_W-1:0];
            jddm_pkg::CSR_MAX_STEP:      slew_step        = setup[i];
            jddm_pkg::CSR_THROTTLE_GAIN: y_gain           = setup[i][jddm_pkg::GAIN_W-1:0];
            jddm_pkg::CSR_STEER_GAIN:    x_gain           = setup[i][jddm_pkg::GAIN_W-1:0];
            jddm_pkg::CSR_THROTTLE_CAP:  throttle_ceiling = setup[i];
            jddm_pkg::CSR_STEER_CAP:     steer_ceiling    = setup[i];
            jddm_pkg::CSR_LEFT_LIMIT:    left_clamp       = setup[i];
            jddm_pkg::CSR_RIGHT_LIMIT:   right_clamp      = setup[i];
         endcase
      end
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic push_sticks(int y, int x);
      stick_pair_type p;
      p.stick_y = y[jddm_pkg::STICK_W-1:0];
      p.stick_x = x[jddm_pkg::STICK_W-1:0];
      stick_queue.push_back(p);
   endtask

   function automatic int pick_stick(int centre);
      case ($urandom_range(0, 5))
         0: return 0;
         1: return 255;
         2: return centre;
         default: return $urandom_range(0, 255);
      endcase
   endfunction

   function automatic int clip_stick(int v);
      return (v < 0) ? 0 : ((v > 255) ? 255 : v);
   endfunction

   // Mostly held stick positions with small jitter, so the filter can settle
   // and reach the caps; the rest is unrelated noise.
   task automatic queue_random_ticks(int count);
      int n, run, base_y, base_x;
      bit noisy;
      n = 0;
      while (n < count) begin
         run    = $urandom_range(1, 40);
         noisy  = ($urandom_range(0, 9) < 2);
         base_y = pick_stick(128);
         base_x = pick_stick(127);
         for (int k = 0; k < run && n < count; k++) begin
            if (noisy) begin
               push_sticks($urandom_range(0, 255), $urandom_range(0, 255));
            end else begin
               push_sticks(clip_stick(base_y + int'($urandom_range(0, 6)) - 3),
                           clip_stick(base_x + int'($urandom_range(0, 6)) - 3));
            end
            n++;
         end
      end
   endtask

   // Value for one register, with junk above its width now and then.
   function automatic logic [CW-1:0] random_setting(int width, int unsigned v);
      logic [CW-1:0] d;
      d = CW'(v);
      if (width < CW && $urandom_range(0, 3) == 0) begin
         d = d | CW'($urandom() << width);
      end
      return d;
   endfunction

   task automatic choose_random_setup();
      int unsigned v;
      case ($urandom_range(0, 9))
         0: v = 65536;
         1: v = $urandom_range(65537, 131071);
         2: v = $urandom_range(1, 255);
         default: v = $urandom_range(256, 65536);
      endcase
      setup[jddm_pkg::CSR_SMOOTHING] = random_setting(jddm_pkg::ALPHA_W, v);
      case ($urandom_range(0, 9))
         0: v = 524287;
         1: v = $urandom_range(0, 15);
         default: v = $urandom_range(100, 60000);
      endcase
      setup[jddm_pkg::CSR_MAX_STEP] = CW'(v);
      for (int i = jddm_pkg::CSR_THROTTLE_GAIN; i <= jddm_pkg::CSR_STEER_GAIN; i++) begin
         case ($urandom_range(0, 9))
            0: v = 0;
            1: v = 4095;
            default: v = $urandom_range(0, 4095);
         endcase
         setup[i] = random_setting(jddm_pkg::GAIN_W, v);
      end
      for (int i = jddm_pkg::CSR_THROTTLE_CAP; i <= jddm_pkg::CSR_RIGHT_LIMIT; i++) begin
         case ($urandom_range(0, 9))
            0: v = 0;
            1: v = 524287;
            default: v = $urandom_range(0, 524287);
         endcase
         setup[i] = CW'(v);
      end
   endtask

   initial begin
      csr_we    <= 1'b0;
      csr_index <= jddm_pkg::CSR_SMOOTHING;
      csr_wdata <= '0;

      smooth_weight    = jddm_pkg::SMOOTHING_RESET;
      slew_step        = jddm_pkg::MAX_STEP_RESET;
      y_gain           = jddm_pkg::THROTTLE_GAIN_RESET;
      x_gain           = jddm_pkg::STEER_GAIN_RESET;
      throttle_ceiling = jddm_pkg::THROTTLE_CAP_RESET;
      steer_ceiling    = jddm_pkg::STEER_CAP_RESET;
      left_clamp       = jddm_pkg::LEFT_LIMIT_RESET;
      right_clamp      = jddm_pkg::RIGHT_LIMIT_RESET;
      throttle_state   = '0;
      steer_state      = '0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings: centred sticks give zero speed, then each stick extreme.
      push_sticks(128, 127);
      push_sticks(0, 127);
      push_sticks(255, 127);
      push_sticks(128, 0);
      push_sticks(128, 255);
      push_sticks(0, 0);
      push_sticks(255, 255);
      push_sticks(0, 255);
      drain();

      // Smoothing weight above one, widest step, full gains, caps and limits.
      setup[jddm_pkg::CSR_SMOOTHING]     = 19'd131071;
      setup[jddm_pkg::CSR_MAX_STEP]      = 19'd524287;
      setup[jddm_pkg::CSR_THROTTLE_GAIN] = 19'd4095;
      setup[jddm_pkg::CSR_STEER_GAIN]    = 19'd4095;
      setup[jddm_pkg::CSR_THROTTLE_CAP]  = 19'd524287;
      setup[jddm_pkg::CSR_STEER_CAP]     = 19'd524287;
      setup[jddm_pkg::CSR_LEFT_LIMIT]    = 19'd524287;
      setup[jddm_pkg::CSR_RIGHT_LIMIT]   = 19'd524287;
      load_setup();
      push_sticks(0, 0);
      push_sticks(0, 255);
      push_sticks(255, 0);
      push_sticks(255, 255);
      push_sticks(128, 127);
      drain();

      // Zero caps: values may still go negative without any lower bound.
      setup[jddm_pkg::CSR_SMOOTHING]    = 19'd65536;
      setup[jddm_pkg::CSR_THROTTLE_CAP] = '0;
      setup[jddm_pkg::CSR_STEER_CAP]    = '0;
      load_setup();
      push_sticks(0, 0);
      push_sticks(255, 255);
      push_sticks(255, 0);
      drain();

      // Everything that can be zero is zero: state frozen, outputs at rest.
      setup[jddm_pkg::CSR_SMOOTHING]     = '0;
      setup[jddm_pkg::CSR_MAX_STEP]      = '0;
      setup[jddm_pkg::CSR_THROTTLE_GAIN] = '0;
      setup[jddm_pkg::CSR_STEER_GAIN]    = '0;
      setup[jddm_pkg::CSR_LEFT_LIMIT]    = '0;
      setup[jddm_pkg::CSR_RIGHT_LIMIT]   = '0;
      load_setup();
      push_sticks(0, 0);
      push_sticks(255, 255);
      drain();

      // Random settings per phase; each phase pauses halfway until all is checked.
      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         choose_random_setup();
         load_setup();
         steady_flow = (ph == 2);
         queue_random_ticks(PHASE_TICKS / 2);
         drain();
         queue_random_ticks(PHASE_TICKS - PHASE_TICKS / 2);
         drain();
         steady_flow = 1'b0;
      end

      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
